@@ hdl/nfsa_pkg.sv @@
// ============================================================================
// nfsa_pkg: shared definitions for the next-fit slot allocator
// Cell geometry, default sizes, request and status codes, and the structs
// that pass between the controller and the row of slot cells.
// ============================================================================
package nfsa_pkg;

  // Each cell owns a fixed group of slots.
  localparam int CELL_SLOTS = 8;
  localparam int OFF_W      = $clog2(CELL_SLOTS);

  localparam int SLOTS_DEF  = 256;
  localparam int KINDS_DEF  = 5;

  localparam int KIND_W     = 3;
  localparam int HANDLE_W   = 8;
  localparam int CNT_W      = 8;

  // Request selector carried with each request transaction.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Status carried with each result transaction.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  // Search token handed from a cell to its right-hand neighbor.
  typedef struct packed {
    logic vld;
    logic first;  // set on the visit that opens a search
  } tok_t;

  // Per-cell command from the controller.
  typedef struct packed {
    logic             launch;    // start a search in this cell
    logic             free;      // clear the slot at free_off
    logic             is_start;  // this cell holds the search pointer
    logic [OFF_W-1:0] scan_off;  // pointer offset inside the start cell
    logic [OFF_W-1:0] free_off;
  } cmd_t;

  // Per-cell response to the controller.
  typedef struct packed {
    logic             busy;     // cell holds the token
    logic             hit;      // free slot found and claimed
    logic             miss;     // search came back around with nothing
    logic             was_act;  // slot named by the last free was active
    logic [OFF_W-1:0] pos;      // claimed slot inside the cell
  } rsp_t;

  // Slots of a cell that exist and may be handed out (slot 0 never is).
  function automatic logic [CELL_SLOTS-1:0] slot_exists(input int cidx, input int slots);
    int                    s;
    logic [CELL_SLOTS-1:0] m;
    m = '0;
    for (int b = 0; b < CELL_SLOTS; b++) begin
      s = cidx * CELL_SLOTS + b;
      m[b] = (s != 0) && (s < slots);
    end
    return m;
  endfunction

endpackage

@@ hdl/nfsa_cell.sv @@
// ============================================================================
// nfsa_cell: one cell of the slot ring
// Holds the active marks of a group of slots, searches them when it holds
// the token, and passes the token on to its neighbor when nothing is free.
// ============================================================================
module nfsa_cell #(
  parameter int SLOTS    = nfsa_pkg::SLOTS_DEF,
  parameter int CELL_IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nfsa_pkg::cmd_t cmd_i,
  input  nfsa_pkg::tok_t tok_i,
  output nfsa_pkg::tok_t tok_o,
  output nfsa_pkg::rsp_t rsp_o
);

  localparam int W = nfsa_pkg::CELL_SLOTS;
  localparam logic [W-1:0] EXISTS = nfsa_pkg::slot_exists(CELL_IDX, SLOTS);

  logic [W-1:0]                 act_q, act_d;
  nfsa_pkg::tok_t               tok_q, tok_d;
  logic                         was_act_q, was_act_d;
  logic [W-1:0]                 win, cand;
  logic                         last, hit;
  logic [nfsa_pkg::OFF_W-1:0]   pos;

  always_comb begin
    // A token that is not on its first visit and sits in the start cell has
    // gone all the way around; only the slots below the pointer remain.
    last = tok_q.vld && !tok_q.first && cmd_i.is_start;
    for (int b = 0; b < W; b++) begin
      if (tok_q.first) begin
        win[b] = nfsa_pkg::OFF_W'(b) >= cmd_i.scan_off;
      end else if (last) begin
        win[b] = nfsa_pkg::OFF_W'(b) < cmd_i.scan_off;
      end else begin
        win[b] = 1'b1;
      end
    end
    cand = ~act_q & EXISTS & win & {W{tok_q.vld}};
    hit  = |cand;
    pos  = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        pos = nfsa_pkg::OFF_W'(b);
      end
    end

    act_d = act_q;
    if (hit) begin
      act_d[pos] = 1'b1;
    end
    if (cmd_i.free) begin
      act_d[cmd_i.free_off] = 1'b0;
    end
    was_act_d = cmd_i.free && act_q[cmd_i.free_off];

    tok_o.vld   = tok_q.vld && !hit && !last;
    tok_o.first = 1'b0;
    if (cmd_i.launch) begin
      tok_d.vld   = 1'b1;
      tok_d.first = 1'b1;
    end else begin
      tok_d = tok_i;
    end

    rsp_o.busy    = tok_q.vld;
    rsp_o.hit     = hit;
    rsp_o.miss    = last && !hit;
    rsp_o.was_act = was_act_q;
    rsp_o.pos     = pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= '0;
      tok_q     <= '0;
      was_act_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      tok_q     <= tok_d;
      was_act_q <= was_act_d;
    end
  end

endmodule

@@ hdl/next_fit_slot_allocator_core.sv @@
// ============================================================================
// next_fit_slot_allocator_core: next-fit handle allocator with kind counters
// Hands out slot handles from a rotating pointer, frees them again and keeps
// a saturating count of active slots per kind.
// ============================================================================
// Usage. Requests arrive on the s_axis channel: tuser selects allocate (0) or
// free (1), tdata carries the kind and the handle. Each request transaction
// yields exactly one result transaction on m_axis: tuser holds the status
// (ok, pool full, bad request), tdata the granted handle and the count of the
// requested kind after the request.
// The active marks live in a ring of cells of eight slots each. An allocate
// injects a token into the cell that holds the search pointer; each cycle the
// token either claims the lowest free slot of its cell or moves on to the
// next cell. A rejected request goes straight to the report step, a free
// passes the free step first and an allocate the scan step, where a full pool
// visits every cell and the start cell twice. The report step loads the output
// register. The input is ready again in the cycle the result appears, and no
// new request is taken while one is still being worked.
// Reset clears all active marks, the counters and the pointer (slot 1) at
// once; no sweep follows. A stalled receiver holds the result in the output
// register; one further request can be accepted and worked, and it then waits
// in its report step until the output register frees up.
// ============================================================================
module next_fit_slot_allocator_core #(
  parameter int SLOTS = nfsa_pkg::SLOTS_DEF,
  parameter int KINDS = nfsa_pkg::KINDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [2:0] ent_kind, [10:3] handle, [15:11] zero
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] granted_handle, [15:8] kind_total
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int OFF_W  = nfsa_pkg::OFF_W;
  localparam int NCELLS = (SLOTS + nfsa_pkg::CELL_SLOTS - 1) / nfsa_pkg::CELL_SLOTS;
  localparam int CIDX_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int SIDX_W = CIDX_W + OFF_W;
  localparam int MEM_AW = $clog2(SLOTS);
  localparam int KIDX_W = (KINDS > 1) ? $clog2(KINDS) : 1;
  localparam int KIND_W = nfsa_pkg::KIND_W;
  localparam int CNT_W  = nfsa_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_RPT
  } state_e;

  state_e                          state_q;
  logic [SIDX_W-1:0]               search_start_q;
  logic [KIND_W-1:0]               req_kind_q;
  logic [1:0]                      status_q;
  logic [nfsa_pkg::HANDLE_W-1:0]   grant_q;
  logic [CNT_W-1:0]                cnt_q [KINDS];
  logic                            m_valid_q;
  logic [15:0]                     m_tdata_q;
  logic [1:0]                      m_tuser_q;

  logic [KIND_W-1:0]               kind_mem [SLOTS];
  logic [KIND_W-1:0]               kind_rd_q;

  // Input fields.
  logic                            in_type;
  logic [KIND_W-1:0]               in_kind;
  logic [nfsa_pkg::HANDLE_W-1:0]   in_handle;
  logic                            accept, alloc_go, free_go, hdl_ok;
  logic [SIDX_W-1:0]               hdl_slot;

  // Cell ring.
  nfsa_pkg::cmd_t                  cmd  [NCELLS];
  nfsa_pkg::tok_t                  tok  [NCELLS];
  nfsa_pkg::rsp_t                  rsp  [NCELLS];
  logic [NCELLS-1:0]               busy_vec;
  logic                            any_hit, any_miss, any_was;
  logic [SIDX_W-1:0]               hit_slot, next_start;
  logic [SIDX_W:0]                 slot_inc;

  // Kind counter port.
  logic [KIND_W-1:0]               cnt_kind;
  logic                            cnt_ok;
  logic [KIDX_W-1:0]               cnt_idx;
  logic [CNT_W-1:0]                cnt_rd;

  assign in_type   = s_axis_tuser;
  assign in_kind   = s_axis_tdata[2:0];
  assign in_handle = s_axis_tdata[10:3];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign hdl_ok   = (in_handle != '0) && (int'(in_handle) < SLOTS);
  assign hdl_slot = SIDX_W'(in_handle);
  assign alloc_go = (in_type == nfsa_pkg::REQ_ALLOC) && (int'(in_kind) < KINDS);
  assign free_go  = (in_type != nfsa_pkg::REQ_ALLOC) && hdl_ok;

  // Commands to each cell; only the addressed cell acts on launch or free.
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    always_comb begin
      cmd[i].launch   = accept && alloc_go &&
                        (search_start_q[SIDX_W-1:OFF_W] == CIDX_W'(i));
      cmd[i].free     = accept && free_go && (hdl_slot[SIDX_W-1:OFF_W] == CIDX_W'(i));
      cmd[i].is_start = (search_start_q[SIDX_W-1:OFF_W] == CIDX_W'(i));
      cmd[i].scan_off = search_start_q[OFF_W-1:0];
      cmd[i].free_off = hdl_slot[OFF_W-1:0];
    end

    nfsa_cell #(
      .SLOTS    (SLOTS),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[i]),
      .tok_i  (tok[(i + NCELLS - 1) % NCELLS]),
      .tok_o  (tok[i]),
      .rsp_o  (rsp[i])
    );

    assign busy_vec[i] = rsp[i].busy;
  end

  // At most one cell holds the token, so the responses can simply be OR-ed.
  always_comb begin
    any_hit  = 1'b0;
    any_miss = 1'b0;
    any_was  = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < NCELLS; i++) begin
      any_miss = any_miss | rsp[i].miss;
      any_was  = any_was | rsp[i].was_act;
      if (rsp[i].hit) begin
        any_hit  = 1'b1;
        hit_slot = hit_slot | {CIDX_W'(i), rsp[i].pos};
      end
    end
    slot_inc   = {1'b0, hit_slot} + 1'b1;
    next_start = (int'(slot_inc) >= SLOTS) ? SIDX_W'(1) : slot_inc[SIDX_W-1:0];
  end

  // One counter read port: the stored kind while freeing, else the request kind.
  always_comb begin
    cnt_kind = (state_q == ST_FREE) ? kind_rd_q : req_kind_q;
    cnt_ok   = int'(cnt_kind) < KINDS;
    cnt_idx  = KIDX_W'(cnt_kind);
    cnt_rd   = cnt_ok ? cnt_q[cnt_idx] : '0;
  end

  // Kind store: written when a slot is claimed, read when a free is accepted.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && any_hit) begin
      kind_mem[hit_slot[MEM_AW-1:0]] <= req_kind_q;
    end
    if (accept && free_go) begin
      kind_rd_q <= kind_mem[hdl_slot[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      search_start_q <= SIDX_W'(1);
      req_kind_q     <= '0;
      status_q       <= nfsa_pkg::STAT_OK;
      grant_q        <= '0;
      m_valid_q      <= 1'b0;
      m_tdata_q      <= '0;
      m_tuser_q      <= nfsa_pkg::STAT_OK;
      for (int k = 0; k < KINDS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      // The report step refills the output register itself when it fires.
      if (m_valid_q && m_axis_tready && (state_q != ST_RPT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_kind_q <= in_kind;
            grant_q    <= '0;
            if (alloc_go) begin
              status_q <= nfsa_pkg::STAT_OK;
              state_q  <= ST_SCAN;
            end else if (free_go) begin
              status_q <= nfsa_pkg::STAT_OK;
              state_q  <= ST_FREE;
            end else begin
              status_q <= nfsa_pkg::STAT_BAD;
              state_q  <= ST_RPT;
            end
          end
        end
        ST_SCAN: begin
          if (any_hit) begin
            grant_q        <= nfsa_pkg::HANDLE_W'(hit_slot);
            search_start_q <= next_start;
            if (cnt_ok && (cnt_rd != {CNT_W{1'b1}})) begin
              cnt_q[cnt_idx] <= cnt_rd + 1'b1;
            end
            state_q <= ST_RPT;
          end else if (any_miss) begin
            status_q <= nfsa_pkg::STAT_FULL;
            state_q  <= ST_RPT;
          end
        end
        ST_FREE: begin
          if (any_was) begin
            if (cnt_ok && (cnt_rd != '0)) begin
              cnt_q[cnt_idx] <= cnt_rd - 1'b1;
            end
          end else begin
            status_q <= nfsa_pkg::STAT_BAD;
          end
          state_q <= ST_RPT;
        end
        ST_RPT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_tdata_q <= {cnt_rd, grant_q};
            m_tuser_q <= status_q;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  // The token is unique and lives only while a search runs.
  a_tok_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(busy_vec))
    else $error("more than one cell holds the search token");

  a_idle_no_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_SCAN) |-> (busy_vec == '0))
    else $error("search token present outside a search");

  a_hit_miss_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(any_hit && any_miss))
    else $error("search reported both a claimed slot and a full pool");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (search_start_q != '0) && (int'(search_start_q) < SLOTS))
    else $error("search pointer left the valid slot range");

  a_was_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_was |-> (state_q == ST_FREE))
    else $error("free probe answer outside the free step");

endmodule
